FILE: rtl/radial_value_brush_pixel_core_defines.svh
// Assertion macros for the radial value brush checker.
// Depends on a clk and an active-low arst_n in the scope of each use.
`ifndef RADIAL_VALUE_BRUSH_PIXEL_CORE_DEFINES_SVH
`define RADIAL_VALUE_BRUSH_PIXEL_CORE_DEFINES_SVH

// same-cycle implication
`define RVB_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvb check failed");

// next-cycle implication
`define RVB_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvb check failed");

`endif

FILE: rtl/rvb_pkg.sv
// Shared types and constants of the radial value brush.
// No dependencies.
`default_nettype none
package rvb_pkg;
	localparam int RADIUS_W = 12;
	localparam int HARD_W   = 17;
	localparam int INT_W    = 9;
	localparam int COORD_W  = 16;

	localparam logic [HARD_W-1:0] HARD_ONE = 17'h10000;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = 12'd1;
	localparam logic signed [INT_W-1:0] INT_RESET = 9'sd20;
	localparam logic signed [INT_W-1:0] INT_MIN = -9'sd255;
	localparam logic signed [INT_W-1:0] INT_BAD = 9'h100;

	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_RADIUS   = 3'd2;
	localparam logic [2:0] REG_HARDNESS = 3'd3;
	localparam logic [2:0] REG_INTENSITY = 3'd4;

	typedef struct packed {
		logic              touched;
		logic signed [9:0] hue;
		logic [7:0]        sat;
		logic [7:0]        val;
	} meta_t;
endpackage
`default_nettype wire

FILE: rtl/radial_value_brush_pixel_core.sv
// Radial value brush: register file, front end, queue and back end.
// Depends on rvb_pkg, rvb_front, rvb_queue and rvb_back.
//
// Use: program center, radius, hardness and intensity over the APB port
// (byte addresses 0, 4, 8, 12, 16) while no pixel is in flight. Present a
// pixel on pixel_x, pixel_y, hue_in, sat_in and value_in with start high; it
// is taken at a clock edge where start is high and busy is low.
// One pixel is taken every cycle while busy is low. Each pixel gives one result, in order,
// on hue_out, sat_out, value_out and touched while done is high for a single
// cycle; the receiver cannot hold it off.
// The path from the accepting edge to the result runs through the
// bit-per-stage square root and bit-per-stage divide pipelines.
// The queue between front and back drains every cycle, so busy stays low in
// normal operation; it rises only if the queue ever nears full.
// Reset clears all pipeline valid bits and loads the register defaults:
// center 0,0, radius 1, hardness 1.0, intensity 20.
`default_nettype none
module radial_value_brush_pixel_core #(
	parameter int MAX_RADIUS = 2048,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [4:0]                        paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [rvb_pkg::COORD_W-1:0]       pixel_x,
	input  wire logic [rvb_pkg::COORD_W-1:0]       pixel_y,
	input  wire logic signed [9:0]                 hue_in,
	input  wire logic [7:0]                        sat_in,
	input  wire logic [7:0]                        value_in,
	output logic                                   done,
	output logic signed [9:0]                      hue_out,
	output logic [7:0]                             sat_out,
	output logic [7:0]                             value_out,
	output logic                                   touched
);
	import rvb_pkg::*;

	localparam int RW = $clog2(MAX_RADIUS + 1);
	localparam int MW = $bits(meta_t) + 2*RW + 1;

	logic [COORD_W-1:0] cx_q, cy_q;
	logic [RW-1:0] radius_q;
	logic [HARD_W-1:0] hard_q;
	logic signed [INT_W-1:0] int_q;
	logic wr;
	logic [2:0] idx;
	logic [RADIUS_W-1:0] r_w;
	logic signed [INT_W-1:0] i_w;

	logic f_valid;
	meta_t f_meta;
	logic [2*RW:0] f_sum;
	logic [MW-1:0] q_data;
	logic q_empty;
	meta_t b_meta;
	logic [2*RW:0] b_sum;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[4:2];
	assign r_w    = pwdata[RADIUS_W-1:0];
	assign i_w    = pwdata[INT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			radius_q <= RW'(RADIUS_RESET);
			hard_q   <= HARD_ONE;
			int_q    <= INT_RESET;
		end else if (wr) begin
			case (idx)
				REG_CENTER_X: cx_q <= pwdata[COORD_W-1:0];
				REG_CENTER_Y: cy_q <= pwdata[COORD_W-1:0];
				REG_RADIUS: begin
					if (r_w == '0) begin
						radius_q <= RW'(RADIUS_RESET);
					end else if ({20'd0, r_w} > 32'(MAX_RADIUS)) begin
						radius_q <= RW'(MAX_RADIUS);
					end else begin
						radius_q <= RW'(r_w);
					end
				end
				REG_HARDNESS: hard_q <= (pwdata[HARD_W-1:0] > HARD_ONE) ?
					HARD_ONE : pwdata[HARD_W-1:0];
				REG_INTENSITY: int_q <= (i_w == INT_BAD) ? INT_MIN : i_w;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CENTER_X:  prdata = {16'h0000, cx_q};
			REG_CENTER_Y:  prdata = {16'h0000, cy_q};
			REG_RADIUS:    prdata = 32'(radius_q);
			REG_HARDNESS:  prdata = {15'h0000, hard_q};
			REG_INTENSITY: prdata = 32'(int_q);
			default:       prdata = '0;
		endcase
	end

	rvb_front #(.RW(RW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.hue_in   (hue_in),
		.sat_in   (sat_in),
		.value_in (value_in),
		.center_x (cx_q),
		.center_y (cy_q),
		.radius   (radius_q),
		.out_valid(f_valid),
		.out_meta (f_meta),
		.out_sum  (f_sum)
	);

	rvb_queue #(.W(MW), .DEPTH(8), .SLACK(3)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_valid),
		.push_data({f_meta, f_sum}),
		.pop      (!q_empty),
		.pop_data (q_data),
		.empty    (q_empty),
		.near_full(busy)
	);

	assign b_meta = q_data[MW-1 -: $bits(meta_t)];
	assign b_sum  = q_data[2*RW:0];

	rvb_back #(.RW(RW), .FB(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (!q_empty),
		.in_meta  (b_meta),
		.in_sum   (b_sum),
		.radius   (radius_q),
		.hardness (hard_q),
		.intensity(int_q),
		.done     (done),
		.hue_out  (hue_out),
		.sat_out  (sat_out),
		.value_out(value_out),
		.touched  (touched)
	);
endmodule
`default_nettype wire

FILE: rtl/rvb_front.sv
// Front end: offsets from the brush center, window test, squared distance.
// Depends on rvb_pkg.
`default_nettype none
module rvb_front #(
	parameter int RW = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [rvb_pkg::COORD_W-1:0]  pixel_x,
	input  wire logic [rvb_pkg::COORD_W-1:0]  pixel_y,
	input  wire logic signed [9:0]            hue_in,
	input  wire logic [7:0]                   sat_in,
	input  wire logic [7:0]                   value_in,
	input  wire logic [rvb_pkg::COORD_W-1:0]  center_x,
	input  wire logic [rvb_pkg::COORD_W-1:0]  center_y,
	input  wire logic [RW-1:0]                radius,
	output logic                              out_valid,
	output rvb_pkg::meta_t                    out_meta,
	output logic [2*RW:0]                     out_sum
);
	import rvb_pkg::*;

	logic signed [17:0] dx, dy, rs;
	logic [17:0] adx, ady;
	logic inx, iny;
	logic [2*RW-1:0] rr_q;

	logic v_s1, v_s2, v_s3;
	meta_t m_s1, m_s2, m_s3;
	logic in_s1, in_s2;
	logic [RW-1:0] adx_s1, ady_s1;
	logic [2*RW-1:0] sqx_s2, sqy_s2;
	logic [2*RW:0] sum_w, sum_s3;

	assign dx  = $signed({2'b00, pixel_x}) - $signed({2'b00, center_x});
	assign dy  = $signed({2'b00, pixel_y}) - $signed({2'b00, center_y});
	assign rs  = $signed({{(18-RW){1'b0}}, radius});
	assign inx = (dx >= -rs) && (dx < rs);
	assign iny = (dy >= -rs) && (dy < rs);
	assign adx = dx[17] ? 18'(-dx) : 18'(dx);
	assign ady = dy[17] ? 18'(-dy) : 18'(dy);
	assign sum_w = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		rr_q <= radius * radius;
		m_s1 <= '{touched: 1'b0, hue: hue_in, sat: sat_in, val: value_in};
		in_s1 <= inx && iny;
		adx_s1 <= adx[RW-1:0];
		ady_s1 <= ady[RW-1:0];
		m_s2 <= m_s1;
		in_s2 <= in_s1;
		sqx_s2 <= adx_s1 * adx_s1;
		sqy_s2 <= ady_s1 * ady_s1;
		m_s3 <= '{touched: in_s2 && (sum_w <= {1'b0, rr_q}), hue: m_s2.hue,
			sat: m_s2.sat, val: m_s2.val};
		sum_s3 <= sum_w;
	end

	assign out_valid = v_s3;
	assign out_meta  = m_s3;
	assign out_sum   = sum_s3;
endmodule
`default_nettype wire

FILE: rtl/rvb_queue.sv
// Short queue between the front end and the back end.
// No dependencies.
`default_nettype none
module rvb_queue #(
	parameter int W = 8,
	parameter int DEPTH = 8,
	parameter int SLACK = 3
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      pop_data,
	output logic              empty,
	output logic              near_full
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0] mem [0:DEPTH-1];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic do_pop;

	assign empty     = (cnt_q == '0);
	assign near_full = (cnt_q >= (AW+1)'(DEPTH - SLACK));
	assign do_pop    = pop && !empty;
	assign pop_data  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

FILE: rtl/rvb_back.sv
// Back end: pipelined square root, falloff divide, scale and clamp.
// Depends on rvb_pkg.
`default_nettype none
module rvb_back #(
	parameter int RW = 12,
	parameter int FB = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	input  wire rvb_pkg::meta_t                    in_meta,
	input  wire logic [2*RW:0]                     in_sum,
	input  wire logic [RW-1:0]                     radius,
	input  wire logic [rvb_pkg::HARD_W-1:0]        hardness,
	input  wire logic signed [rvb_pkg::INT_W-1:0]  intensity,
	output logic                                   done,
	output logic signed [9:0]                      hue_out,
	output logic [7:0]                             sat_out,
	output logic [7:0]                             value_out,
	output logic                                   touched
);
	import rvb_pkg::*;

	localparam int NB = RW + 9;
	localparam int PW = RW + 17;
	localparam int DW = RW + 18;
	localparam int TW = FB + 12;

	logic [PW-1:0] rh_q, den_q;

	logic          sq_v_s    [0:NB];
	meta_t         sq_m_s    [0:NB];
	logic [NB+1:0] sq_rem_s  [0:NB];
	logic [NB-1:0] sq_root_s [0:NB];
	logic [2*NB-1:0] sq_rad_s [0:NB];

	logic [PW-1:0] dq16, num, numc;
	logic full_w;
	logic v_s1;
	meta_t m_s1;
	logic full_s1;
	logic [PW-1:0] d_s1;

	logic          dv_v_s    [0:FB+1];
	meta_t         dv_m_s    [0:FB+1];
	logic          dv_full_s [0:FB+1];
	logic [DW-1:0] dv_rem_s  [0:FB+1];
	logic [FB:0]   dv_quo_s  [0:FB+1];

	logic [FB:0] factor;
	logic v_s2;
	meta_t m_s2;
	logic signed [FB+10:0] prod_s2;
	logic signed [TW-1:0] total;
	logic [TW-FB-1:0] whole;
	logic [7:0] vnew;

	always_ff @(posedge clk) begin
		rh_q  <= radius * hardness;
		den_q <= radius * 17'(HARD_ONE - hardness);
	end

	assign sq_v_s[0]    = in_valid;
	assign sq_m_s[0]    = in_meta;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_rad_s[0]  = {1'b0, in_sum, 16'h0000};

	for (genvar k = 0; k < NB; k++) begin : g_sq
		logic [NB+3:0] a, b, diff;
		logic ge;
		assign a    = {sq_rem_s[k], sq_rad_s[k][2*NB-1 -: 2]};
		assign b    = {2'b00, sq_root_s[k], 2'b01};
		assign ge   = (a >= b);
		assign diff = a - b;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			sq_m_s[k+1]    <= sq_m_s[k];
			sq_rem_s[k+1]  <= ge ? diff[NB+1:0] : a[NB+1:0];
			sq_root_s[k+1] <= {sq_root_s[k][NB-2:0], ge};
			sq_rad_s[k+1]  <= {sq_rad_s[k][2*NB-3:0], 2'b00};
		end
	end

	assign dq16   = {sq_root_s[NB], 8'h00};
	assign full_w = (dq16 <= rh_q) || (den_q == '0);
	assign num    = dq16 - rh_q;
	assign numc   = (num > den_q) ? den_q : num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= sq_v_s[NB];
			v_s2 <= dv_v_s[FB+1];
			done <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		m_s1    <= sq_m_s[NB];
		full_s1 <= full_w;
		d_s1    <= den_q - numc;
	end

	assign dv_v_s[0]    = v_s1;
	assign dv_m_s[0]    = m_s1;
	assign dv_full_s[0] = full_s1;
	assign dv_rem_s[0]  = {1'b0, d_s1};
	assign dv_quo_s[0]  = '0;

	for (genvar j = 0; j <= FB; j++) begin : g_dv
		logic [DW-1:0] a, diff;
		logic ge;
		if (j == 0) begin : g_first
			assign a = dv_rem_s[j];
		end else begin : g_rest
			assign a = {dv_rem_s[j][DW-2:0], 1'b0};
		end
		assign ge   = (a >= {1'b0, den_q});
		assign diff = a - {1'b0, den_q};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end
		always_ff @(posedge clk) begin
			dv_m_s[j+1]    <= dv_m_s[j];
			dv_full_s[j+1] <= dv_full_s[j];
			dv_rem_s[j+1]  <= ge ? diff : a;
			dv_quo_s[j+1]  <= {dv_quo_s[j][FB-1:0], ge};
		end
	end

	assign factor = dv_full_s[FB+1] ? {1'b1, {FB{1'b0}}} : dv_quo_s[FB+1];

	always_ff @(posedge clk) begin
		m_s2    <= dv_m_s[FB+1];
		prod_s2 <= intensity * $signed({1'b0, factor});
	end

	assign total = $signed({4'h0, m_s2.val, {FB{1'b0}}}) + TW'(prod_s2);
	assign whole = total[TW-1:FB];
	assign vnew  = total[TW-1] ? 8'h00 :
		((whole > (TW-FB)'(255)) ? 8'hFF : whole[7:0]);

	always_ff @(posedge clk) begin
		hue_out   <= m_s2.hue;
		sat_out   <= m_s2.sat;
		touched   <= m_s2.touched;
		value_out <= m_s2.touched ? vnew : m_s2.val;
	end
endmodule
`default_nettype wire

FILE: rtl/rvb_checker.sv
// Port-level checks of the radial value brush, bound to the top level.
// Depends on radial_value_brush_pixel_core_defines.svh.
`default_nettype none
`include "radial_value_brush_pixel_core_defines.svh"
module rvb_checker #(
	parameter int MAX_RADIUS = 2048,
	parameter int FRAC_BITS = 16
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              start,
	input wire logic              busy,
	input wire logic signed [9:0] hue_in,
	input wire logic [7:0]        sat_in,
	input wire logic [7:0]        value_in,
	input wire logic              done,
	input wire logic signed [9:0] hue_out,
	input wire logic [7:0]        sat_out,
	input wire logic [7:0]        value_out,
	input wire logic              touched
);
	localparam int LAT = $clog2(MAX_RADIUS + 1) + FRAC_BITS + 17;

	`RVB_CHECK(a_done_follows_beat, done, $past(start && !busy, LAT))
	`RVB_CHECK(a_pass_through, done, (hue_out == $past(hue_in, LAT)) && (sat_out == $past(sat_in, LAT)))
	`RVB_CHECK(a_untouched_value, done && !touched, value_out == $past(value_in, LAT))
	`RVB_CHECK_NEXT(a_queue_drains, !busy, !busy)
endmodule

bind radial_value_brush_pixel_core rvb_checker #(
	.MAX_RADIUS(MAX_RADIUS),
	.FRAC_BITS (FRAC_BITS)
) u_rvb_checker (.*);
`default_nettype wire
